FILE: src/ffc_pkg.sv
// Shared types, constants and helper functions for the frame flood classifier.
// No dependencies; used by frame_flood_classifier_unit and its checker.
package ffc_pkg;

  // Counter width of the window counters (legal range 16..64).
  localparam int COUNT_W = 32;
  // Width used for comparing counters against 32-bit limits.
  localparam int LIM_W   = (COUNT_W > 32) ? COUNT_W : 32;
  // Width for the exact share tests (x*10 needs four more bits).
  localparam int SHARE_W = COUNT_W + 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RATE_OUT_W = 32;

  typedef logic [COUNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SYN  = 2'd1,
    KIND_UDP  = 2'd2,
    KIND_ICMP = 2'd3
  } kind_t;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SYN_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYN_RATE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UDP_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UDP_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ICMP_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ICMP_RATE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSIZE   = 3'd6;

  // Reset values of the limits
  localparam logic [31:0] RST_SYN_COUNT  = 32'd100;
  localparam logic [31:0] RST_SYN_RATE   = 32'd50;
  localparam logic [31:0] RST_UDP_COUNT  = 32'd500;
  localparam logic [31:0] RST_UDP_RATE   = 32'd100;
  localparam logic [31:0] RST_ICMP_COUNT = 32'd100;
  localparam logic [31:0] RST_ICMP_RATE  = 32'd50;
  localparam logic [15:0] RST_OVERSIZE   = 16'd2000;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Saturating increment
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (&v) ? v : v + COUNT_W'(1);
  endfunction

  // Clamp a counter to the 32-bit output field
  function automatic logic [RATE_OUT_W-1:0] sat_out(input cnt_t v);
    if (LIM_W'(v) > LIM_W'({RATE_OUT_W{1'b1}})) begin
      sat_out = {RATE_OUT_W{1'b1}};
    end else begin
      sat_out = RATE_OUT_W'(v);
    end
  endfunction

  // Compare a counter against a 32-bit limit: v > lim
  function automatic logic above_lim(input cnt_t v, input logic [31:0] lim);
    above_lim = LIM_W'(v) > LIM_W'(lim);
  endfunction

endpackage

FILE: src/frame_flood_classifier_unit.sv
// Frame flood classifier top level: window counters, flood/scan/promiscuity flags.
// Depends on ffc_pkg (types, constants, saturating helpers).
//
//  channel | ports                  | handshake     | payload
//  --------+------------------------+---------------+--------------------------------------
//  input   | in_valid / in_ready    | valid-ready   | op, dest_mac, ether_type, ip_protocol,
//          |                        |               | tcp_syn, tcp_ack, frame_length
//  result  | out_valid / out_ready  | valid-ready   | attack_flag, attack_kind, scan_flag,
//          |                        |               | promisc_flag, packet_rate, frame_total
//  config  | cfg_wr_en              | write strobe  | cfg_index, cfg_wdata
//
// Throughput is one item per clock while the result register is not stalled. An input
// transfer loads the input register, which feeds the counter update; its combinational
// read-modify-write of the window state sets the rate; the result register loads as the
// item advances and raises out_valid. rst_n is synchronous, active low; it restores the
// limit defaults and zeroes all window state. With out_ready low the result register
// holds and the input register may still fill; in_ready drops only when both are occupied.
module frame_flood_classifier_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [47:0]                    in_dest_mac,
  input  logic [15:0]                    in_ether_type,
  input  logic [7:0]                     in_ip_protocol,
  input  logic                           in_tcp_syn,
  input  logic                           in_tcp_ack,
  input  logic [15:0]                    in_frame_length,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_attack_flag,
  output logic [1:0]                     out_attack_kind,
  output logic                           out_scan_flag,
  output logic                           out_promisc_flag,
  output logic [31:0]                    out_packet_rate,
  output logic [31:0]                    out_frame_total,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [ffc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------- limits
  logic [31:0] syn_cnt_lim_r, syn_rate_lim_r;
  logic [31:0] udp_cnt_lim_r, udp_rate_lim_r;
  logic [31:0] icmp_cnt_lim_r, icmp_rate_lim_r;
  logic [15:0] oversize_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syn_cnt_lim_r   <= ffc_pkg::RST_SYN_COUNT;
      syn_rate_lim_r  <= ffc_pkg::RST_SYN_RATE;
      udp_cnt_lim_r   <= ffc_pkg::RST_UDP_COUNT;
      udp_rate_lim_r  <= ffc_pkg::RST_UDP_RATE;
      icmp_cnt_lim_r  <= ffc_pkg::RST_ICMP_COUNT;
      icmp_rate_lim_r <= ffc_pkg::RST_ICMP_RATE;
      oversize_len_r  <= ffc_pkg::RST_OVERSIZE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ffc_pkg::CFG_SYN_COUNT:  syn_cnt_lim_r   <= cfg_wdata;
        ffc_pkg::CFG_SYN_RATE:   syn_rate_lim_r  <= cfg_wdata;
        ffc_pkg::CFG_UDP_COUNT:  udp_cnt_lim_r   <= cfg_wdata;
        ffc_pkg::CFG_UDP_RATE:   udp_rate_lim_r  <= cfg_wdata;
        ffc_pkg::CFG_ICMP_COUNT: icmp_cnt_lim_r  <= cfg_wdata;
        ffc_pkg::CFG_ICMP_RATE:  icmp_rate_lim_r <= cfg_wdata;
        ffc_pkg::CFG_OVERSIZE:   oversize_len_r  <= cfg_wdata[15:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- input stage
  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [47:0] s1_mac_r;
  logic [15:0] s1_etype_r;
  logic [7:0]  s1_proto_r;
  logic        s1_syn_r, s1_ack_r;
  logic [15:0] s1_len_r;

  logic out_valid_r;
  logic advance;       // item in the input stage moves into state and result

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= in_op;
      s1_mac_r   <= in_dest_mac;
      s1_etype_r <= in_ether_type;
      s1_proto_r <= in_ip_protocol;
      s1_syn_r   <= in_tcp_syn;
      s1_ack_r   <= in_tcp_ack;
      s1_len_r   <= in_frame_length;
    end
  end

  // ---------------------------------------------------------------- window state
  ffc_pkg::cnt_t  total_r, bcast_r, mcast_r, syn_r, udp_r, icmp_r, oversize_r;
  ffc_pkg::cnt_t  last_tick_r, rate_r;
  logic           attack_r, scan_r, promisc_r;
  ffc_pkg::kind_t kind_r;

  ffc_pkg::cnt_t  total_nxt, bcast_nxt, mcast_nxt, syn_nxt, udp_nxt, icmp_nxt;
  ffc_pkg::cnt_t  oversize_nxt, last_tick_nxt, rate_nxt;
  logic           attack_nxt, scan_nxt, promisc_nxt;
  ffc_pkg::kind_t kind_nxt;

  // exact share tests on the updated counts: 10*bcast > 3*total, 10*mcast > 4*total
  logic [ffc_pkg::SHARE_W-1:0] bcast_x10, mcast_x10, total_x3, total_x4;
  logic                        share_high;

  assign bcast_x10 = (ffc_pkg::SHARE_W'(bcast_nxt) << 3) + (ffc_pkg::SHARE_W'(bcast_nxt) << 1);
  assign mcast_x10 = (ffc_pkg::SHARE_W'(mcast_nxt) << 3) + (ffc_pkg::SHARE_W'(mcast_nxt) << 1);
  assign total_x3  = (ffc_pkg::SHARE_W'(total_nxt) << 1) + ffc_pkg::SHARE_W'(total_nxt);
  assign total_x4  = ffc_pkg::SHARE_W'(total_nxt) << 2;
  assign share_high = (bcast_x10 > total_x3) || (mcast_x10 > total_x4);

  always_comb begin
    total_nxt     = total_r;
    bcast_nxt     = bcast_r;
    mcast_nxt     = mcast_r;
    syn_nxt       = syn_r;
    udp_nxt       = udp_r;
    icmp_nxt      = icmp_r;
    oversize_nxt  = oversize_r;
    last_tick_nxt = last_tick_r;
    rate_nxt      = rate_r;
    attack_nxt    = attack_r;
    scan_nxt      = scan_r;
    promisc_nxt   = promisc_r;
    kind_nxt      = kind_r;

    unique case (s1_op_r)
      ffc_pkg::OP_FRAME: begin
        total_nxt = ffc_pkg::sat_inc(total_r);
        // all-ones destination is broadcast only; otherwise group bit means multicast
        if (&s1_mac_r) begin
          bcast_nxt = ffc_pkg::sat_inc(bcast_r);
        end else if (s1_mac_r[40]) begin
          mcast_nxt = ffc_pkg::sat_inc(mcast_r);
        end

        if (s1_etype_r == ffc_pkg::ETYPE_IPV4) begin
          if (s1_len_r > oversize_len_r) begin
            oversize_nxt = ffc_pkg::sat_inc(oversize_r);
          end

          case (s1_proto_r)
            ffc_pkg::PROTO_TCP: begin
              if (s1_syn_r && !s1_ack_r) begin
                syn_nxt = ffc_pkg::sat_inc(syn_r);
                if (ffc_pkg::above_lim(syn_nxt, syn_cnt_lim_r) &&
                    ffc_pkg::above_lim(rate_r, syn_rate_lim_r)) begin
                  attack_nxt = 1'b1;
                  kind_nxt   = ffc_pkg::KIND_SYN;
                  scan_nxt   = 1'b1;
                end
              end
            end
            ffc_pkg::PROTO_UDP: begin
              udp_nxt = ffc_pkg::sat_inc(udp_r);
              if (ffc_pkg::above_lim(udp_nxt, udp_cnt_lim_r) &&
                  ffc_pkg::above_lim(rate_r, udp_rate_lim_r)) begin
                attack_nxt = 1'b1;
                kind_nxt   = ffc_pkg::KIND_UDP;
                scan_nxt   = 1'b1;
              end
            end
            ffc_pkg::PROTO_ICMP: begin
              icmp_nxt = ffc_pkg::sat_inc(icmp_r);
              if (ffc_pkg::above_lim(icmp_nxt, icmp_cnt_lim_r) &&
                  ffc_pkg::above_lim(rate_r, icmp_rate_lim_r)) begin
                attack_nxt = 1'b1;
                kind_nxt   = ffc_pkg::KIND_ICMP;
              end
            end
            default: ;
          endcase

          if (share_high) begin
            promisc_nxt = 1'b1;
          end
        end
      end
      ffc_pkg::OP_TICK: begin
        // frames since the previous tick, modulo the counter width
        rate_nxt      = total_r - last_tick_r;
        last_tick_nxt = total_r;
      end
      ffc_pkg::OP_CLEAR: begin
        total_nxt     = '0;
        bcast_nxt     = '0;
        mcast_nxt     = '0;
        syn_nxt       = '0;
        udp_nxt       = '0;
        icmp_nxt      = '0;
        oversize_nxt  = '0;
        last_tick_nxt = '0;
        rate_nxt      = '0;
        attack_nxt    = 1'b0;
        scan_nxt      = 1'b0;
        promisc_nxt   = 1'b0;
        kind_nxt      = ffc_pkg::KIND_NONE;
      end
      default: ;  // unused op: state unchanged, result reports it
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      bcast_r     <= '0;
      mcast_r     <= '0;
      syn_r       <= '0;
      udp_r       <= '0;
      icmp_r      <= '0;
      oversize_r  <= '0;
      last_tick_r <= '0;
      rate_r      <= '0;
      attack_r    <= 1'b0;
      scan_r      <= 1'b0;
      promisc_r   <= 1'b0;
      kind_r      <= ffc_pkg::KIND_NONE;
    end else if (advance) begin
      total_r     <= total_nxt;
      bcast_r     <= bcast_nxt;
      mcast_r     <= mcast_nxt;
      syn_r       <= syn_nxt;
      udp_r       <= udp_nxt;
      icmp_r      <= icmp_nxt;
      oversize_r  <= oversize_nxt;
      last_tick_r <= last_tick_nxt;
      rate_r      <= rate_nxt;
      attack_r    <= attack_nxt;
      scan_r      <= scan_nxt;
      promisc_r   <= promisc_nxt;
      kind_r      <= kind_nxt;
    end
  end

  // ---------------------------------------------------------------- result register
  logic        res_attack_r, res_scan_r, res_promisc_r;
  logic [1:0]  res_kind_r;
  logic [31:0] res_rate_r, res_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_attack_r  <= attack_nxt;
      res_kind_r    <= kind_nxt;
      res_scan_r    <= scan_nxt;
      res_promisc_r <= promisc_nxt;
      res_rate_r    <= ffc_pkg::sat_out(rate_nxt);
      res_total_r   <= ffc_pkg::sat_out(total_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_attack_flag  = res_attack_r;
  assign out_attack_kind  = res_kind_r;
  assign out_scan_flag    = res_scan_r;
  assign out_promisc_flag = res_promisc_r;
  assign out_packet_rate  = res_rate_r;
  assign out_frame_total  = res_total_r;

endmodule

FILE: src/ffc_checker.sv
// Port-level checker for frame_flood_classifier_unit, bound to the top level.
// Depends on ffc_pkg for the flood kind codes.
module ffc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_attack_flag,
  input logic [1:0]  out_attack_kind,
  input logic        out_scan_flag,
  input logic        out_promisc_flag,
  input logic [31:0] out_packet_rate,
  input logic [31:0] out_frame_total
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_attack_flag) &&
      $stable(out_attack_kind) && $stable(out_scan_flag) && $stable(out_promisc_flag) &&
      $stable(out_packet_rate) && $stable(out_frame_total))
    else $error("result changed while stalled");

  // the flood kind is set exactly when the sticky flood flag is
  a_kind_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_attack_flag == (out_attack_kind != ffc_pkg::KIND_NONE))
    else $error("flood kind and flood flag disagree");

  // a scan only comes from a flood
  a_scan_flood: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_flag |-> out_attack_flag)
    else $error("scan flag without flood flag");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_flood_classifier_unit ffc_checker u_ffc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_attack_flag  (out_attack_flag),
  .out_attack_kind  (out_attack_kind),
  .out_scan_flag    (out_scan_flag),
  .out_promisc_flag (out_promisc_flag),
  .out_packet_rate  (out_packet_rate),
  .out_frame_total  (out_frame_total)
);
